// ----- hw/rtl/wtps_pkg.sv -----
// Package for the word tokenizer: microcode types, step labels, status and
// control bundles, punctuation lookup functions.
// No dependencies.
package wtps_pkg;

    // Datapath action of one microcode step
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_PUSH,
        ACT_PUNCT_OUT,
        ACT_CHAR_OUT,
        ACT_MARK_OUT
    } wtps_act_t;

    // Jump condition of one microcode step
    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_SPACE,
        COND_PUNCT,
        COND_PEND_EMPTY,
        COND_PEND_MORE,
        COND_NOT_EOT,
        COND_NOT_IN_WORD
    } wtps_cond_t;

    // How run_last is set on an emitted word
    typedef enum logic [1:0] {
        LAST_NO,
        LAST_YES,
        LAST_NOT_EOT
    } wtps_last_t;

    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] wtps_step_t;

    localparam wtps_step_t STEP_FETCH      = 4'd0;
    localparam wtps_step_t STEP_TEST_SPACE = 4'd1;
    localparam wtps_step_t STEP_TEST_PUNCT = 4'd2;
    localparam wtps_step_t STEP_TEST_PEND  = 4'd3;
    localparam wtps_step_t STEP_DRAIN      = 4'd4;
    localparam wtps_step_t STEP_CHAR       = 4'd5;
    localparam wtps_step_t STEP_PUSH       = 4'd6;
    localparam wtps_step_t STEP_TEST_EOT   = 4'd7;
    localparam wtps_step_t STEP_TEST_OPEN  = 4'd8;
    localparam wtps_step_t STEP_CLOSE      = 4'd9;

    // One control word of the microprogram
    typedef struct packed {
        wtps_act_t  act;
        wtps_cond_t cond;
        wtps_step_t target;
        wtps_last_t last_sel;
    } wtps_uword_t;

    // Sequencer to datapath
    typedef struct packed {
        wtps_act_t  act;
        wtps_last_t last_sel;
    } wtps_ctrl_t;

    // Datapath to sequencer
    typedef struct packed {
        logic is_space;
        logic is_punct;
        logic pend_empty;
        logic pend_more;
        logic eot;
        logic in_word;
        logic out_free;
    } wtps_status_t;

    localparam logic [3:0]  PUNCT_NONE = 4'd15;
    localparam logic [15:0] WORD_MAX   = 16'hFFFF;
    localparam logic [7:0]  CHAR_UPPER_A = 8'h41;
    localparam logic [7:0]  CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0]  CASE_OFFSET  = 8'h20;

    // Map a byte to its punctuation code, or PUNCT_NONE
    function automatic logic [3:0] punct_code(input logic [7:0] b);
        logic [3:0] c;
        unique case (b)
            8'h2E:   c = 4'd0;   // .
            8'h2C:   c = 4'd1;   // ,
            8'h3F:   c = 4'd2;   // ?
            8'h2D:   c = 4'd3;   // -
            8'h3B:   c = 4'd4;   // ;
            8'h3A:   c = 4'd5;   // :
            8'h28:   c = 4'd6;   // (
            8'h29:   c = 4'd7;   // )
            8'h5B:   c = 4'd8;   // [
            8'h5D:   c = 4'd9;   // ]
            8'h21:   c = 4'd10;  // !
            8'h22:   c = 4'd11;  // double quote
            8'h27:   c = 4'd12;  // single quote
            default: c = PUNCT_NONE;
        endcase
        return c;
    endfunction

    // Map a punctuation code back to its byte
    function automatic logic [7:0] punct_char(input logic [3:0] c);
        logic [7:0] b;
        unique case (c)
            4'd0:    b = 8'h2E;
            4'd1:    b = 8'h2C;
            4'd2:    b = 8'h3F;
            4'd3:    b = 8'h2D;
            4'd4:    b = 8'h3B;
            4'd5:    b = 8'h3A;
            4'd6:    b = 8'h28;
            4'd7:    b = 8'h29;
            4'd8:    b = 8'h5B;
            4'd9:    b = 8'h5D;
            4'd10:   b = 8'h21;
            4'd11:   b = 8'h22;
            4'd12:   b = 8'h27;
            default: b = 8'h2E;
        endcase
        return b;
    endfunction

    // Whitespace: space, newline, tab, vertical tab, carriage return, form feed
    function automatic logic is_space_char(input logic [7:0] b);
        return (b == 8'h20) || (b == 8'h0A) || (b == 8'h09) ||
               (b == 8'h0B) || (b == 8'h0D) || (b == 8'h0C);
    endfunction

endpackage

// ----- hw/rtl/wtps_seq.sv -----
// Microcode sequencer: step counter, control ROM and jump logic.
// Depends on wtps_pkg.
module wtps_seq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  wtps_pkg::wtps_status_t status,
    output wtps_pkg::wtps_ctrl_t   ctrl,
    output logic                  s_ready
);
    import wtps_pkg::*;

    wtps_step_t  pc_reg;
    wtps_step_t  pc_next;
    wtps_uword_t uw;
    logic        cond_true;
    logic        emit_step;

    // Control ROM
    always_comb begin
        unique case (pc_reg)
            STEP_FETCH:      uw = '{ACT_LOAD,      COND_NO_INPUT,    STEP_FETCH,     LAST_NO};
            STEP_TEST_SPACE: uw = '{ACT_NONE,      COND_SPACE,       STEP_TEST_OPEN, LAST_NO};
            STEP_TEST_PUNCT: uw = '{ACT_NONE,      COND_PUNCT,       STEP_PUSH,      LAST_NO};
            STEP_TEST_PEND:  uw = '{ACT_NONE,      COND_PEND_EMPTY,  STEP_CHAR,      LAST_NO};
            STEP_DRAIN:      uw = '{ACT_PUNCT_OUT, COND_PEND_MORE,   STEP_DRAIN,     LAST_NO};
            STEP_CHAR:       uw = '{ACT_CHAR_OUT,  COND_ALWAYS,      STEP_TEST_EOT,  LAST_NOT_EOT};
            STEP_PUSH:       uw = '{ACT_PUSH,      COND_ALWAYS,      STEP_TEST_EOT,  LAST_NO};
            STEP_TEST_EOT:   uw = '{ACT_NONE,      COND_NOT_EOT,     STEP_FETCH,     LAST_NO};
            STEP_TEST_OPEN:  uw = '{ACT_NONE,      COND_NOT_IN_WORD, STEP_FETCH,     LAST_NO};
            STEP_CLOSE:      uw = '{ACT_MARK_OUT,  COND_ALWAYS,      STEP_FETCH,     LAST_YES};
            default:         uw = '{ACT_NONE,      COND_ALWAYS,      STEP_FETCH,     LAST_NO};
        endcase
    end

    // Evaluate jump condition
    always_comb begin
        unique case (uw.cond)
            COND_ALWAYS:      cond_true = 1'b1;
            COND_NO_INPUT:    cond_true = !s_valid;
            COND_SPACE:       cond_true = status.is_space;
            COND_PUNCT:       cond_true = status.is_punct;
            COND_PEND_EMPTY:  cond_true = status.pend_empty;
            COND_PEND_MORE:   cond_true = status.pend_more;
            COND_NOT_EOT:     cond_true = !status.eot;
            COND_NOT_IN_WORD: cond_true = !status.in_word;
            default:          cond_true = 1'b1;
        endcase
    end

    assign emit_step = (uw.act == ACT_PUNCT_OUT) || (uw.act == ACT_CHAR_OUT) ||
                       (uw.act == ACT_MARK_OUT);

    // Hold on a blocked output, else jump or advance
    always_comb begin
        if (emit_step && !status.out_free) begin
            pc_next = pc_reg;
        end else if (cond_true) begin
            pc_next = uw.target;
        end else begin
            pc_next = wtps_step_t'(pc_reg + 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= STEP_FETCH;
        end else begin
            pc_reg <= pc_next;
        end
    end

    assign ctrl.act      = uw.act;
    assign ctrl.last_sel = uw.last_sel;
    assign s_ready       = (uw.act == ACT_LOAD);

endmodule

// ----- hw/rtl/wtps_dp.sv -----
// Tokenizer datapath: input latch, token flags, pending punctuation memory,
// word counter and output register. Depends on wtps_pkg.
module wtps_dp #(
    parameter int PENDING_DEPTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  wtps_pkg::wtps_ctrl_t   ctrl,
    input  logic                  s_valid,
    input  logic [7:0]            s_text_byte,
    input  logic                  s_end_of_text,
    output wtps_pkg::wtps_status_t status,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_item_kind,
    output logic [7:0]            m_word_char,
    output logic [15:0]           m_word_number,
    output logic                  m_run_last
);
    import wtps_pkg::*;

    localparam int CW = $clog2(PENDING_DEPTH + 1);
    localparam int AW = $clog2(PENDING_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(PENDING_DEPTH);

    logic [7:0]    byte_reg;
    logic          eot_reg;
    logic          in_word_reg, in_word_next;
    logic          body_reg, body_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [15:0]   words_reg, words_next;
    logic [3:0]    pend_mem [PENDING_DEPTH];
    logic [3:0]    rd_data_reg;

    logic          m_valid_reg, m_valid_next;
    logic          kind_reg, kind_next;
    logic [7:0]    char_reg, char_next;
    logic [15:0]   num_reg, num_next;
    logic          last_reg, last_next;

    logic [3:0]    code;
    logic          out_free;
    logic          emit;
    logic          push_en;
    logic [CW-1:0] idx_plus;
    logic [7:0]    lower_char;
    logic [15:0]   words_inc;
    logic          last_bit;

    // Classify the latched byte
    assign code       = punct_code(byte_reg);
    assign out_free   = !m_valid_reg || m_ready;
    assign emit       = out_free && ((ctrl.act == ACT_PUNCT_OUT) ||
                        (ctrl.act == ACT_CHAR_OUT) || (ctrl.act == ACT_MARK_OUT));
    assign push_en    = (ctrl.act == ACT_PUSH) && body_reg && (count_reg < DEPTH_C);
    assign idx_plus   = CW'(idx_reg + 1'b1);
    assign lower_char = ((byte_reg >= CHAR_UPPER_A) && (byte_reg <= CHAR_UPPER_Z)) ?
                        8'(byte_reg + CASE_OFFSET) : byte_reg;
    assign words_inc  = (words_reg == WORD_MAX) ? words_reg : 16'(words_reg + 1'b1);

    // Report status to the sequencer
    assign status.is_space   = is_space_char(byte_reg);
    assign status.is_punct   = (code != PUNCT_NONE);
    assign status.pend_empty = (count_reg == '0);
    assign status.pend_more  = (idx_plus != count_reg);
    assign status.eot        = eot_reg;
    assign status.in_word    = in_word_reg;
    assign status.out_free   = out_free;

    // Token state update
    always_comb begin
        in_word_next = in_word_reg;
        body_next    = body_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        words_next   = words_reg;
        case (ctrl.act)
            ACT_LOAD: begin
                idx_next = '0;
            end
            ACT_PUSH: begin
                in_word_next = 1'b1;
                if (push_en) begin
                    count_next = CW'(count_reg + 1'b1);
                end
            end
            ACT_PUNCT_OUT: begin
                if (out_free) begin
                    idx_next = idx_plus;
                end
            end
            ACT_CHAR_OUT: begin
                if (out_free) begin
                    in_word_next = 1'b1;
                    body_next    = 1'b1;
                    count_next   = '0;
                end
            end
            ACT_MARK_OUT: begin
                if (out_free) begin
                    words_next   = words_inc;
                    in_word_next = 1'b0;
                    body_next    = 1'b0;
                    count_next   = '0;
                end
            end
            default: ;
        endcase
    end

    // Select run_last for the emitted word
    always_comb begin
        unique case (ctrl.last_sel)
            LAST_NO:      last_bit = 1'b0;
            LAST_YES:     last_bit = 1'b1;
            LAST_NOT_EOT: last_bit = !eot_reg;
            default:      last_bit = 1'b0;
        endcase
    end

    // Output register load
    always_comb begin
        kind_next    = kind_reg;
        char_next    = char_reg;
        num_next     = num_reg;
        last_next    = last_reg;
        m_valid_next = m_ready ? 1'b0 : m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            last_next    = last_bit;
            case (ctrl.act)
                ACT_PUNCT_OUT: begin
                    kind_next = 1'b0;
                    char_next = punct_char(rd_data_reg);
                    num_next  = '0;
                end
                ACT_CHAR_OUT: begin
                    kind_next = 1'b0;
                    char_next = lower_char;
                    num_next  = '0;
                end
                default: begin
                    kind_next = 1'b1;
                    char_next = '0;
                    num_next  = words_inc;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_word_reg <= 1'b0;
            body_reg    <= 1'b0;
            count_reg   <= '0;
            idx_reg     <= '0;
            words_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            in_word_reg <= in_word_next;
            body_reg    <= body_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            words_reg   <= words_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (ctrl.act == ACT_LOAD && s_valid) begin
            byte_reg <= s_text_byte;
            eot_reg  <= s_end_of_text;
        end
        kind_reg <= kind_next;
        char_reg <= char_next;
        num_reg  <= num_next;
        last_reg <= last_next;
    end

    // Pending punctuation memory: write on push, registered read at next index
    always_ff @(posedge aclk) begin
        if (push_en) begin
            pend_mem[count_reg[AW-1:0]] <= code;
        end
        rd_data_reg <= pend_mem[idx_next[AW-1:0]];
    end

    assign m_valid       = m_valid_reg;
    assign m_item_kind   = kind_reg;
    assign m_word_char   = char_reg;
    assign m_word_number = num_reg;
    assign m_run_last    = last_reg;

endmodule

// ----- hw/rtl/word_tokenizer_punct_strip.sv -----
// Top level of the byte-serial word tokenizer with punctuation trim.
// Depends on wtps_pkg, wtps_seq and wtps_dp.
//
// Usage: text enters one byte per word on the s_ channel (s_text_byte,
// s_end_of_text); results leave on the m_ channel as lowercased word bytes
// (m_item_kind 0) and end-of-word markers (m_item_kind 1) that carry the
// saturating word count. m_run_last flags the last result of an input byte.
// Both channels use valid/ready and move a word when both are high.
// Sequencing: a microcoded sequencer runs a ten-step program per input byte.
// A whitespace byte outside a word passes fetch, space test and open test;
// a body byte that also ends the text passes fetch, the space, punctuation
// and pending tests, character output, end-of-text test, open test, close,
// plus a drain step per held punctuation byte it releases.
// A result sits in an output register, so the next byte is accepted while
// the last result of the previous one waits to be taken.
// Stall: while m_ready is low with a result held, any step that emits
// holds its place and the sequencer stops until the register frees.
// Reset: aresetn (synchronous, active low) returns the sequencer to its
// fetch step, closes any open word and clears the word count. The pending
// punctuation store needs no clearing.
module word_tokenizer_punct_strip #(
    parameter int PENDING_DEPTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_text_byte,
    input  logic        s_end_of_text,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_item_kind,
    output logic [7:0]  m_word_char,
    output logic [15:0] m_word_number,
    output logic        m_run_last
);
    import wtps_pkg::*;

    wtps_ctrl_t   ctrl;
    wtps_status_t status;

    // Microcode sequencer
    wtps_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .status  (status),
        .ctrl    (ctrl),
        .s_ready (s_ready)
    );

    // Datapath
    wtps_dp #(
        .PENDING_DEPTH (PENDING_DEPTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctrl          (ctrl),
        .s_valid       (s_valid),
        .s_text_byte   (s_text_byte),
        .s_end_of_text (s_end_of_text),
        .status        (status),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_item_kind   (m_item_kind),
        .m_word_char   (m_word_char),
        .m_word_number (m_word_number),
        .m_run_last    (m_run_last)
    );

endmodule
